>>> rtl/rpn_pkg.sv
package rpn_pkg;

   localparam int unsigned STACK_DEPTH_DEF = 64;
   localparam int unsigned MIN_OPERANDS = 2;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_POW  = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FEW       = 3'd1,
      ST_FULL      = 3'd2,
      ST_UNKNOWN   = 3'd3,
      ST_DIV_ZERO  = 3'd4,
      ST_EMPTY_END = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ALU_MUL = 2'd0,
      ALU_DIV = 2'd1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic sat;
   } alu_stat_type;

endpackage

>>> rtl/rpn_ram.sv
module rpn_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rpn_alu.sv
module rpn_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  rpn_pkg::alu_cmd_type cmd,
   input  logic signed [31:0]   a,
   input  logic signed [31:0]   b,
   input  logic                 div_big,
   output rpn_pkg::alu_stat_type stat,
   output logic signed [31:0]   result
);
   import rpn_pkg::*;

   // Q16.16 multiply (product, then floor/clip) or (a<<shift)/b restoring
   // division, one quotient bit per cycle.

   typedef enum logic [2:0] {
      A_IDLE, A_MUL1, A_MUL2, A_DIV, A_DIVFIN
   } astate_type;

   astate_type          state_ff, state_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic [48:0]         num_ff, num_in;
   logic [48:0]         quo_ff, quo_in;
   logic [32:0]         rem_ff, rem_in;
   logic [31:0]         den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic signed [31:0]  res_ff, res_in;
   logic                sat_ff, sat_in;
   logic                done_ff, done_in;

   logic signed [47:0]  mfloor;
   logic [32:0]         trial;
   logic [32:0]         shifted;
   logic [31:0]         abs_a;
   logic [31:0]         abs_b;

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      sat_in   = sat_ff;
      done_in  = 1'b0;
      mfloor   = prod_ff[63:16];
      abs_a    = a[31] ? 32'(-a) : 32'(a);
      abs_b    = b[31] ? 32'(-b) : 32'(b);
      shifted  = {rem_ff[31:0], num_ff[48]};
      trial    = shifted - {1'b0, den_ff};
      case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               if (cmd.op == ALU_MUL) begin
                  prod_in  = 64'(a) * 64'(b);
                  state_in = A_MUL1;
               end else begin
                  num_in   = div_big ? {1'b0, abs_a, 16'd0} : {17'd0, abs_a};
                  num_in   = div_big ? {abs_a[31:0], 17'd0} >> 1 : num_in;
                  num_in   = div_big ? {1'b0, abs_a, 16'd0} : {17'd0, abs_a};
                  quo_in   = '0;
                  rem_in   = '0;
                  den_in   = abs_b;
                  neg_in   = a[31] ^ b[31];
                  cnt_in   = 6'd49 - 6'd1;
                  state_in = A_DIV;
               end
            end
         end
         A_MUL1: begin
            state_in = A_MUL2;
         end
         A_MUL2: begin
            sat_in = 1'b0;
            if (mfloor > 48'sh0000_7FFF_FFFF) begin
               res_in = 32'sh7FFF_FFFF; sat_in = 1'b1;
            end else if (mfloor < -48'sh0000_8000_0000) begin
               res_in = 32'sh8000_0000; sat_in = 1'b1;
            end else begin
               res_in = mfloor[31:0];
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         A_DIV: begin
            num_in = {num_ff[47:0], 1'b0};
            if (!trial[32]) begin
               rem_in = trial;
               quo_in = {quo_ff[47:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[47:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = A_DIVFIN;
            end
         end
         A_DIVFIN: begin
            sat_in = 1'b0;
            if (neg_ff) begin
               if (quo_ff > 49'h0_8000_0000) begin
                  res_in = 32'sh8000_0000; sat_in = 1'b1;
               end else begin
                  res_in = 32'(-quo_ff[31:0]);
               end
            end else if (quo_ff > 49'h0_7FFF_FFFF) begin
               res_in = 32'sh7FFF_FFFF; sat_in = 1'b1;
            end else begin
               res_in = quo_ff[31:0];
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      sat_ff  <= sat_in;
   end

   assign stat.busy = (state_ff != A_IDLE);
   assign stat.done = done_ff;
   assign stat.sat  = sat_ff;
   assign result    = res_ff;

endmodule

>>> rtl/rpn_stack_evaluator_core.sv
// RPN evaluator, signed Q16.16.
// req channel: one transaction per postfix item (opcode, value, last).
// rsp channel: exactly one transaction per item with the top of stack,
// status, saturation flag, depth and done mark.
// The operand stack is a single-port-write, registered-read RAM; x and y are
// fetched in two reads. One shared unit does multiply and division, the
// latter one quotient bit per cycle. Power squares and multiplies over the
// integer bits of |n|; a negative n adds a reciprocal division. req_tready
// is low from acceptance until the response is taken; one item is in flight
// at a time.
// A response waits in its register while rsp_tready is low.
// Reset empties the stack; RAM contents are not cleared.
module rpn_stack_evaluator_core #(
   parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // opcode[2:0], value[34:3], zero pad
   input  logic        req_tlast,  // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // top_value[31:0], status[34:32],
                                   // saturated[35], stack_depth[42:36], pad
   output logic        rsp_tlast   // done_res
);
   import rpn_pkg::*;

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RDY, S_RDX, S_CAPX, S_OP, S_PMUL, S_PSQ,
      S_PINV, S_WAIT, S_WRITE, S_RDTOP, S_TOP, S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [2:0]         op_ff, op_in;
   logic signed [31:0] val_ff, val_in;
   logic               last_ff, last_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] p_ff, p_in;
   logic [15:0]        e_ff, e_in;
   logic               nneg_ff, nneg_in;
   logic               sat_ff, sat_in;
   logic [1:0]         tgt_ff, tgt_in;
   logic signed [31:0] r_ff, r_in;
   logic [2:0]         status_ff, status_in;
   logic signed [31:0] top_ff, top_in;
   logic               done_ff, done_in;
   logic               rvalid_ff, rvalid_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        rd_data;

   alu_cmd_type        acmd;
   alu_stat_type       astat;
   logic signed [31:0] aa, ab, ares;
   logic               adiv_big;
   logic [16:0]        nmag;
   logic [33:0]        addsub;

   rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   rpn_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (acmd),
      .a      (aa),
      .b      (ab),
      .div_big(adiv_big),
      .stat   (astat),
      .result (ares)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      last_in   = last_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      p_in      = p_ff;
      e_in      = e_ff;
      nneg_in   = nneg_ff;
      sat_in    = sat_ff;
      tgt_in    = tgt_ff;
      r_in      = r_ff;
      status_in = status_ff;
      top_in    = top_ff;
      done_in   = done_ff;
      rvalid_in = rvalid_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = r_ff;
      rd_addr   = AW'(count_ff - CW'(1));
      acmd.start = 1'b0;
      acmd.op    = ALU_MUL;
      aa        = p_ff;
      ab        = x_ff;
      adiv_big  = 1'b1;
      nmag      = y_ff[31] ? 17'(-(33'(y_ff) >>> 16)) : 17'(y_ff[31:16]);
      nmag      = y_ff[31] ? 17'((-{y_ff[31], y_ff}) >> 16) : nmag;
      addsub    = (op_ff == OP_SUB) ? 34'(35'(x_ff) - 35'(y_ff))
                                     : 34'(35'(x_ff) + 35'(y_ff));
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[2:0];
               val_in   = req_tdata[34:3];
               last_in  = req_tlast;
               sat_in   = 1'b0;
               status_in = ST_OK;
               done_in  = 1'b0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (op_ff == OP_PUSH) begin
               if (count_ff >= CW'(STACK_DEPTH)) begin
                  status_in = ST_FULL;
                  state_in  = S_TOP;
               end else begin
                  r_in     = val_ff;
                  state_in = S_WRITE;
               end
            end else if (op_ff > OP_POW) begin
               status_in = ST_UNKNOWN;
               state_in  = S_TOP;
            end else if (count_ff < CW'(MIN_OPERANDS)) begin
               status_in = ST_FEW;
               state_in  = S_TOP;
            end else begin
               state_in = S_RDY;
            end
         end
         S_RDY: begin
            y_in     = rd_data;
            rd_addr  = AW'(count_ff - CW'(2));
            state_in = S_RDX;
         end
         S_RDX: begin
            x_in     = rd_data;
            state_in = S_CAPX;
         end
         S_CAPX: begin
            count_in = count_ff - CW'(2);
            state_in = S_OP;
         end
         S_OP: begin
            case (op_ff)
               OP_ADD, OP_SUB: begin
                  if ($signed(addsub) > 34'sh0_7FFF_FFFF) begin
                     r_in = 32'sh7FFF_FFFF; sat_in = 1'b1;
                  end else if ($signed(addsub) < -34'sh0_8000_0000) begin
                     r_in = 32'sh8000_0000; sat_in = 1'b1;
                  end else begin
                     r_in = addsub[31:0];
                  end
                  state_in = S_WRITE;
               end
               OP_MUL: begin
                  acmd.start = 1'b1;
                  aa = x_ff; ab = y_ff;
                  tgt_in   = 2'd0;
                  state_in = S_WAIT;
               end
               OP_DIV: begin
                  if (y_ff == 32'sd0) begin
                     status_in = ST_DIV_ZERO;
                     state_in  = S_TOP;
                  end else begin
                     acmd.start = 1'b1;
                     acmd.op    = ALU_DIV;
                     aa = x_ff; ab = y_ff;
                     tgt_in   = 2'd0;
                     state_in = S_WAIT;
                  end
               end
               default: begin
                  e_in     = nmag[15:0];
                  nneg_in  = y_ff[31] && (nmag != 17'd0);
                  p_in     = 32'sh0001_0000;
                  state_in = S_PMUL;
               end
            endcase
         end
         S_PMUL: begin
            if (e_ff == 16'd0) begin
               state_in = S_PINV;
            end else if (e_ff[0]) begin
               acmd.start = 1'b1;
               aa = p_ff; ab = x_ff;
               tgt_in   = 2'd1;
               state_in = S_WAIT;
            end else begin
               state_in = S_PSQ;
            end
         end
         S_PSQ: begin
            e_in = e_ff >> 1;
            if ((e_ff >> 1) != 16'd0) begin
               acmd.start = 1'b1;
               aa = x_ff; ab = x_ff;
               tgt_in   = 2'd2;
               state_in = S_WAIT;
            end else begin
               state_in = S_PINV;
            end
         end
         S_PINV: begin
            if (!nneg_ff) begin
               r_in     = p_ff;
               state_in = S_WRITE;
            end else if (p_ff == 32'sd0) begin
               status_in = ST_DIV_ZERO;
               state_in  = S_TOP;
            end else begin
               acmd.start = 1'b1;
               acmd.op    = ALU_DIV;
               aa = 32'sh0001_0000; ab = p_ff;
               tgt_in   = 2'd0;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (astat.done) begin
               sat_in = sat_ff | astat.sat;
               case (tgt_ff)
                  2'd1: begin
                     p_in = ares; state_in = S_PSQ;
                  end
                  2'd2: begin
                     x_in = ares; state_in = S_PMUL;
                  end
                  default: begin
                     r_in = ares; state_in = S_WRITE;
                  end
               endcase
            end
         end
         S_WRITE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            top_in   = r_ff;
            state_in = S_TOP;
         end
         S_TOP: begin
            if (status_ff != ST_OK) begin
               count_in = '0;
               top_in   = '0;
               sat_in   = 1'b0;
            end else if (count_ff == '0) begin
               top_in = '0;
               if (last_ff) status_in = ST_EMPTY_END;
            end else if (op_ff != OP_PUSH && op_ff != OP_ADD && op_ff != OP_SUB
                         && op_ff != OP_MUL && op_ff != OP_DIV
                         && op_ff != OP_POW) begin
               top_in = top_ff;
            end else if (last_ff) begin
               done_in  = 1'b1;
               count_in = '0;
            end
            rvalid_in = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
      op_ff     <= op_in;
      val_ff    <= val_in;
      last_ff   <= last_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      p_ff      <= p_in;
      e_ff      <= e_in;
      nneg_ff   <= nneg_in;
      sat_ff    <= sat_in;
      tgt_ff    <= tgt_in;
      r_ff      <= r_in;
      status_ff <= status_in;
      top_ff    <= top_in;
      done_ff   <= done_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {5'd0, 7'(count_ff), sat_ff, status_ff, top_ff};
   assign rsp_tlast  = done_ff;

endmodule
